// File: sv/rcsfd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Serial channel frame decoder package
// Shared constants and types for the front classifier, the request queue and
// the back end that updates the pending store and emits channel sets.
// ----------------------------------------------------------------------------
package rcsfd_pkg;

   localparam int MAX_CHANNELS = 9;
   localparam int NUM_WORDS    = 7;
   localparam int IDX_W        = $clog2(MAX_CHANNELS);
   localparam int CNT_W        = $clog2(MAX_CHANNELS + 1);

   localparam logic [7:0]  ALL_ONES_BYTE = 8'hFF;
   localparam logic [7:0]  ID10_MASK     = 8'b0111_1100;
   localparam logic [7:0]  ID11_MASK     = 8'b0111_1000;
   localparam logic [7:0]  VAL10_MASK    = 8'b0000_0011;
   localparam logic [7:0]  VAL11_MASK    = 8'b0000_0111;
   localparam logic [10:0] VALUE_OFFSET  = 11'd989;

   typedef struct packed {
      logic             used;
      logic [IDX_W-1:0] id;
      logic [10:0]      value;
   } word_type;

   typedef struct packed {
      logic                         wide;
      logic                         bad;
      word_type [NUM_WORDS-1:0]     words;
   } entry_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

endpackage
`default_nettype wire

// File: sv/rcsfd_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Frame decoder front end
// Detects the packet resolution and decodes the seven channel words into
// id and value pairs, marking the words that survive a bad id.
// ----------------------------------------------------------------------------
module rcsfd_front (
   input  wire logic [63:0]          req_packet_bytes_high,
   input  wire logic [63:0]          req_packet_bytes_low,
   output rcsfd_pkg::entry_type      entry
);

   logic [127:0] packet;
   logic [7:0]   first_byte;
   logic [7:0]   second_byte;
   logic [4:0]   id;
   logic [10:0]  raw;
   logic         used;
   logic         ok;
   logic         wide;

   always_comb begin
      packet      = {req_packet_bytes_high, req_packet_bytes_low};
      wide        = 1'b0;
      first_byte  = 8'd0;
      second_byte = 8'd0;
      id          = 5'd0;
      raw         = 11'd0;
      used        = 1'b0;
      ok          = 1'b1;
      entry       = '0;
      for (int w = 1; w <= rcsfd_pkg::NUM_WORDS; w++) begin
         first_byte  = packet[127 - 16 * w -: 8];
         second_byte = packet[119 - 16 * w -: 8];
         if ((first_byte != rcsfd_pkg::ALL_ONES_BYTE) &&
             (second_byte != rcsfd_pkg::ALL_ONES_BYTE) &&
             (5'((first_byte & rcsfd_pkg::ID10_MASK) >> 2) >=
              5'(rcsfd_pkg::MAX_CHANNELS))) begin
            wide = 1'b1;
         end
      end
      entry.wide = wide;
      for (int w = 1; w <= rcsfd_pkg::NUM_WORDS; w++) begin
         first_byte  = packet[127 - 16 * w -: 8];
         second_byte = packet[119 - 16 * w -: 8];
         if (wide) begin
            id  = 5'((first_byte & rcsfd_pkg::ID11_MASK) >> 3);
            raw = 11'({first_byte & rcsfd_pkg::VAL11_MASK, second_byte} >> 1);
         end else begin
            id  = 5'((first_byte & rcsfd_pkg::ID10_MASK) >> 2);
            raw = 11'({first_byte & rcsfd_pkg::VAL10_MASK, second_byte});
         end
         used = !((first_byte == rcsfd_pkg::ALL_ONES_BYTE) &&
                  (second_byte == rcsfd_pkg::ALL_ONES_BYTE));
         if (used && (id >= 5'(rcsfd_pkg::MAX_CHANNELS))) begin
            ok = 1'b0;
         end
         entry.words[w - 1].used  = used && ok;
         entry.words[w - 1].id    = (rcsfd_pkg::IDX_W)'(id);
         entry.words[w - 1].value = raw + rcsfd_pkg::VALUE_OFFSET;
      end
      entry.bad = !ok;
   end

endmodule
`default_nettype wire

// File: sv/rcsfd_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Frame decoder request queue
// Two-entry queue of classified requests between the front and back ends.
// ----------------------------------------------------------------------------
module rcsfd_queue (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  wire rcsfd_pkg::entry_type      push_entry,
   input  wire logic                      pop,
   output rcsfd_pkg::entry_type           head_entry,
   output rcsfd_pkg::queue_status_type    status
);

   rcsfd_pkg::entry_type slot_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       do_push;
   logic       do_pop;

   always_comb begin
      status.empty = (count_ff == 2'd0);
      status.full  = (count_ff == 2'd2);
      do_push      = push && !status.full;
      do_pop       = pop && !status.empty;
      head_entry   = slot_ff[rd_ptr_ff];
      wr_ptr_in    = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in    = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in     = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule
`default_nettype wire

// File: sv/rcsfd_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Frame decoder back end
// Writes decoded words into the pending store, checks for a complete set and
// emits the set through the response register, one channel per cycle unless stalled.
// ----------------------------------------------------------------------------
module rcsfd_back (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire rcsfd_pkg::entry_type      head_entry,
   input  wire logic                      queue_empty,
   output logic                           pop,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic [3:0]                     rsp_channel_index,
   output logic [10:0]                    rsp_channel_value,
   output logic                           rsp_frame_resolution,
   output logic [3:0]                     rsp_channel_total,
   output logic                           rsp_last_of_set
);

   typedef enum logic [2:0] {
      S_TAKE  = 3'b001,
      S_CHECK = 3'b010,
      S_EMIT  = 3'b100
   } state_type;

   state_type                      state_ff;
   state_type                      state_in;
   logic [10:0]                    store_ff [rcsfd_pkg::MAX_CHANNELS];
   logic [10:0]                    store_in [rcsfd_pkg::MAX_CHANNELS];
   logic [rcsfd_pkg::CNT_W-1:0]    count_ff;
   logic [rcsfd_pkg::CNT_W-1:0]    count_in;
   logic [rcsfd_pkg::CNT_W-1:0]    word_top;
   logic [rcsfd_pkg::IDX_W-1:0]    idx_ff;
   logic [rcsfd_pkg::IDX_W-1:0]    idx_in;
   logic                           wide_ff;
   logic                           wide_in;
   logic                           complete;
   logic                           last;
   logic                           rsp_valid_ff;
   logic                           rsp_valid_in;
   logic [3:0]                     rsp_index_ff;
   logic [3:0]                     rsp_index_in;
   logic [10:0]                    rsp_value_ff;
   logic [10:0]                    rsp_value_in;
   logic                           rsp_wide_ff;
   logic                           rsp_wide_in;
   logic [3:0]                     rsp_total_ff;
   logic [3:0]                     rsp_total_in;
   logic                           rsp_last_ff;
   logic                           rsp_last_in;

   always_comb begin
      state_in     = state_ff;
      store_in     = store_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      wide_in      = wide_ff;
      pop          = 1'b0;
      complete     = 1'b1;
      last         = 1'b0;
      word_top     = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_index_in = rsp_index_ff;
      rsp_value_in = rsp_value_ff;
      rsp_wide_in  = rsp_wide_ff;
      rsp_total_in = rsp_total_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         S_TAKE: begin
            if (!queue_empty) begin
               pop     = 1'b1;
               wide_in = head_entry.wide;
               for (int j = 0; j < rcsfd_pkg::MAX_CHANNELS; j++) begin
                  for (int w = 0; w < rcsfd_pkg::NUM_WORDS; w++) begin
                     if (head_entry.words[w].used &&
                         (head_entry.words[w].id == (rcsfd_pkg::IDX_W)'(j))) begin
                        store_in[j] = head_entry.words[w].value;
                     end
                  end
               end
               for (int w = 0; w < rcsfd_pkg::NUM_WORDS; w++) begin
                  word_top = (rcsfd_pkg::CNT_W)'(head_entry.words[w].id) +
                             (rcsfd_pkg::CNT_W)'(1);
                  if (head_entry.words[w].used && (word_top > count_in)) begin
                     count_in = word_top;
                  end
               end
               // A packet cut short by a bad id skips the completion check.
               if (head_entry.bad) begin
                  state_in = S_TAKE;
               end else begin
                  state_in = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            for (int j = 0; j < rcsfd_pkg::MAX_CHANNELS; j++) begin
               if (((rcsfd_pkg::CNT_W)'(j) < count_ff) && (store_ff[j] == 11'd0)) begin
                  complete = 1'b0;
               end
            end
            idx_in = '0;
            if (complete && (count_ff != '0)) begin
               state_in = S_EMIT;
            end else begin
               state_in = S_TAKE;
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               last             = ((rcsfd_pkg::CNT_W)'(idx_ff) + (rcsfd_pkg::CNT_W)'(1)) ==
                                  count_ff;
               rsp_valid_in     = 1'b1;
               rsp_index_in     = 4'(idx_ff);
               rsp_value_in     = store_ff[idx_ff];
               rsp_wide_in      = wide_ff;
               rsp_total_in     = 4'(count_ff);
               rsp_last_in      = last;
               store_in[idx_ff] = 11'd0;
               if (last) begin
                  state_in = S_TAKE;
               end else begin
                  idx_in = idx_ff + (rcsfd_pkg::IDX_W)'(1);
               end
            end
         end
         default: begin
            state_in = S_TAKE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_TAKE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int j = 0; j < rcsfd_pkg::MAX_CHANNELS; j++) begin
            store_ff[j] <= 11'd0;
         end
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         store_ff     <= store_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      wide_ff      <= wide_in;
      rsp_index_ff <= rsp_index_in;
      rsp_value_ff <= rsp_value_in;
      rsp_wide_ff  <= rsp_wide_in;
      rsp_total_ff <= rsp_total_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_channel_index    = rsp_index_ff;
   assign rsp_channel_value    = rsp_value_ff;
   assign rsp_frame_resolution = rsp_wide_ff;
   assign rsp_channel_total    = rsp_total_ff;
   assign rsp_last_of_set      = rsp_last_ff;

endmodule
`default_nettype wire

// File: sv/rc_serial_channel_frame_decoder_unit.sv
`default_nettype none
// A request is classified as it enters and queued; after it leaves the queue
// the back end stores its words, checks the set and, if it is complete, emits
// it at one channel per cycle while the response side does not stall. A
// request cut short by a bad id skips the check. The two-entry queue absorbs
// bursts meanwhile. Synchronous reset empties the queue and response register
// and clears the pending store.
// ----------------------------------------------------------------------------
// Serial channel frame decoder
// Decodes 16-byte receiver packets into channel values and emits each complete
// channel set in channel order.
// ----------------------------------------------------------------------------
module rc_serial_channel_frame_decoder_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [63:0] req_packet_bytes_high,
   input  wire logic [63:0] req_packet_bytes_low,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [3:0]       rsp_channel_index,
   output logic [10:0]      rsp_channel_value,
   output logic             rsp_frame_resolution,
   output logic [3:0]       rsp_channel_total,
   output logic             rsp_last_of_set
);

   rcsfd_pkg::entry_type          front_entry;
   rcsfd_pkg::entry_type          head_entry;
   rcsfd_pkg::queue_status_type   queue_status;
   logic                          pop;

   rcsfd_front u_front (
      .req_packet_bytes_high (req_packet_bytes_high),
      .req_packet_bytes_low  (req_packet_bytes_low),
      .entry                 (front_entry)
   );

   rcsfd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_valid),
      .push_entry (front_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .status     (queue_status)
   );

   rcsfd_back u_back (
      .clock                (clock),
      .reset                (reset),
      .head_entry           (head_entry),
      .queue_empty          (queue_status.empty),
      .pop                  (pop),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_channel_index    (rsp_channel_index),
      .rsp_channel_value    (rsp_channel_value),
      .rsp_frame_resolution (rsp_frame_resolution),
      .rsp_channel_total    (rsp_channel_total),
      .rsp_last_of_set      (rsp_last_of_set)
   );

   assign req_stall = queue_status.full;

   a_pop_not_empty : assert property (@(posedge clock) disable iff (reset)
      pop |-> !queue_status.empty)
      else $error("Back end popped an empty request queue.");

   a_last_matches_total : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_of_set) |-> ((rsp_channel_index + 4'd1) == rsp_channel_total))
      else $error("Last channel of a set does not match the channel total.");

   a_value_nonzero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_channel_value >= rcsfd_pkg::VALUE_OFFSET))
      else $error("Emitted channel value is below the offset.");

endmodule
`default_nettype wire

// File: tb/tb_rc_serial_channel_frame_decoder_unit.sv
// ----------------------------------------------------------------------------
// Serial channel frame decoder testbench
// Drives 16-byte receiver packets into the decoder and checks every emitted
// channel value against a cycle-free model of the pending store, with random
// idle cycles on the request side and random stalls on the response side.
// ----------------------------------------------------------------------------
module tb_rc_serial_channel_frame_decoder_unit;

   localparam int RANDOM_PACKETS  = 415;
   localparam int SHOWN_MISMATCH  = 10;
   localparam int IDLE_PERCENT    = 13;
   localparam int DRAIN_CYCLES    = 60;
   // An 11-bit word for channel 5 or above always reads as a 10-bit id of 10
   // or more, so it forces the packet to 11-bit resolution unless its second byte is 0xFF.
   localparam int FORCE_WIDE_CHAN = 5;

   typedef struct packed {
      logic [63:0] bytes_high;
      logic [63:0] bytes_low;
      logic        drain;
   } packet_type;

   typedef struct packed {
      logic [3:0]  index;
      logic [10:0] value;
      logic        resolution;
      logic [3:0]  total;
      logic        last;
   } channel_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [63:0] req_packet_bytes_high = '0;
   logic [63:0] req_packet_bytes_low = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [3:0]  rsp_channel_index;
   logic [10:0] rsp_channel_value;
   logic        rsp_frame_resolution;
   logic [3:0]  rsp_channel_total;
   logic        rsp_last_of_set;

   packet_type         packet_queue[$];
   channel_result_type expected_channels[$];
   logic [15:0]        slot_word[1:7] = '{default: 16'hFFFF};
   logic [10:0]        held_value[0:rcsfd_pkg::MAX_CHANNELS-1] = '{default: 11'd0};
   logic [3:0]         held_count = '0;

   int     cycle_no = 0;
   logic   req_taken = 1'b0;
   logic   calm;
   int     mismatch_count = 0;
   int     packets_taken = 0;
   int     bad_id_packets = 0;
   int     channels_checked = 0;
   int     sets_checked = 0;
   int     wide_sets = 0;

   assign calm = (cycle_no >= 2000 && cycle_no < 3500);

   rc_serial_channel_frame_decoder_unit u_top (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_packet_bytes_high(req_packet_bytes_high),
      .req_packet_bytes_low (req_packet_bytes_low),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_channel_index    (rsp_channel_index),
      .rsp_channel_value    (rsp_channel_value),
      .rsp_frame_resolution (rsp_frame_resolution),
      .rsp_channel_total    (rsp_channel_total),
      .rsp_last_of_set      (rsp_last_of_set)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [15:0] word10(logic [4:0] chan, logic [9:0] v);
      return {1'($urandom_range(0, 1)), chan, v};
   endfunction

   function automatic logic [15:0] word11(logic [3:0] chan, logic [10:0] v);
      return {1'($urandom_range(0, 1)), chan, v};
   endfunction

   task automatic send_packet(input logic drain, input logic [15:0] header);
      packet_type p;
      p.bytes_high = {header, slot_word[1], slot_word[2], slot_word[3]};
      p.bytes_low  = {slot_word[4], slot_word[5], slot_word[6], slot_word[7]};
      p.drain      = drain;
      packet_queue.push_back(p);
      for (int w = 1; w <= 7; w++) slot_word[w] = 16'hFFFF;
   endtask

   task automatic shuffle_ints(ref int q[$]);
      int j;
      int t;
      for (int i = q.size() - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         t = q[i];
         q[i] = q[j];
         q[j] = t;
      end
   endtask

   // Queues the packets that carry one full set of channels in random order,
   // each packet at a random resolution, sometimes with a repeated channel.
   task automatic queue_channel_set(output int made);
      int   order[$];
      int   group[$];
      int   spots[$];
      int   at;
      int   n;
      logic wide;
      logic has_high;
      made = 0;
      at = 0;
      order = {};
      for (int c = 0; c < rcsfd_pkg::MAX_CHANNELS; c++) order.push_back(c);
      shuffle_ints(order);
      n = $urandom_range(2, 7);
      while (at < rcsfd_pkg::MAX_CHANNELS) begin
         group = {};
         for (int k = 0; k < n && at < rcsfd_pkg::MAX_CHANNELS; k++) begin
            group.push_back(order[at]);
            at++;
         end
         wide = 1'($urandom_range(0, 1));
         has_high = 1'b0;
         foreach (group[k]) if (group[k] >= FORCE_WIDE_CHAN) has_high = 1'b1;
         if (wide && !has_high) group.push_back($urandom_range(FORCE_WIDE_CHAN, 8));
         if (group.size() < 7 && $urandom_range(0, 3) == 0) group.push_back($urandom_range(0, 8));
         spots = {1, 2, 3, 4, 5, 6, 7};
         shuffle_ints(spots);
         foreach (group[k]) begin
            slot_word[spots[k]] = wide ? word11(4'(group[k]), 11'($urandom))
                                       : word10(5'(group[k]), 10'($urandom));
         end
         send_packet(made == 0 && $urandom_range(0, 39) == 0, 16'($urandom));
         made++;
         n = 7;
      end
   endtask

   // Resolution is chosen over the words with no 0xFF byte; then each word
   // that is not entirely 0xFF updates the pending store until a bad id ends
   // the packet. A complete set is emitted in channel order and cleared.
   task automatic decode_packet(input logic [127:0] pkt);
      logic [7:0]         lead_byte[1:7];
      logic [7:0]         tail_byte[1:7];
      logic               wide;
      logic               dropped;
      logic               complete;
      int unsigned        id;
      logic [10:0]        value;
      channel_result_type r;
      wide = 1'b0;
      dropped = 1'b0;
      complete = 1'b1;
      for (int w = 1; w <= 7; w++) begin
         lead_byte[w] = pkt[127 - 16 * w -: 8];
         tail_byte[w] = pkt[119 - 16 * w -: 8];
      end
      for (int w = 1; w <= 7; w++) begin
         if (lead_byte[w] != rcsfd_pkg::ALL_ONES_BYTE &&
             tail_byte[w] != rcsfd_pkg::ALL_ONES_BYTE &&
             ((lead_byte[w] & rcsfd_pkg::ID10_MASK) >> 2) >= rcsfd_pkg::MAX_CHANNELS) begin
            wide = 1'b1;
         end
      end
      for (int w = 1; w <= 7 && !dropped; w++) begin
         if (lead_byte[w] != rcsfd_pkg::ALL_ONES_BYTE ||
             tail_byte[w] != rcsfd_pkg::ALL_ONES_BYTE) begin
            if (wide) begin
               id = 32'((lead_byte[w] & rcsfd_pkg::ID11_MASK) >> 3);
               value = 11'({lead_byte[w] & rcsfd_pkg::VAL11_MASK, tail_byte[w]} >> 1) +
                       rcsfd_pkg::VALUE_OFFSET;
            end else begin
               id = 32'((lead_byte[w] & rcsfd_pkg::ID10_MASK) >> 2);
               value = 11'({lead_byte[w] & rcsfd_pkg::VAL10_MASK, tail_byte[w]}) +
                       rcsfd_pkg::VALUE_OFFSET;
            end
            if (id >= rcsfd_pkg::MAX_CHANNELS) begin
               dropped = 1'b1;
               bad_id_packets++;
            end else begin
               held_value[id] = value;
               if (id + 1 > held_count) held_count = 4'(id + 1);
            end
         end
      end
      if (!dropped) begin
         for (int c = 0; c < held_count; c++) if (held_value[c] == '0) complete = 1'b0;
         if (complete) begin
            for (int c = 0; c < held_count; c++) begin
               r.index      = 4'(c);
               r.value      = held_value[c];
               r.resolution = wide;
               r.total      = held_count;
               r.last       = (c + 1 == held_count);
               expected_channels.push_back(r);
               held_value[c] = '0;
            end
         end
      end
   endtask

   always @(negedge clock) begin
      packet_type next_packet;
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= !calm && ($urandom_range(0, 99) < IDLE_PERCENT);
         if (!req_valid || req_taken) begin
            if (packet_queue.size() != 0 &&
                !(packet_queue[0].drain && expected_channels.size() != 0) &&
                (calm || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
               next_packet = packet_queue.pop_front();
               req_packet_bytes_high <= next_packet.bytes_high;
               req_packet_bytes_low  <= next_packet.bytes_low;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      channel_result_type got;
      channel_result_type want;
      cycle_no  <= cycle_no + 1;
      req_taken <= !reset && req_valid && !req_stall;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_channel_index, rsp_channel_value, rsp_frame_resolution,
                    rsp_channel_total, rsp_last_of_set};
            if (expected_channels.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= SHOWN_MISMATCH) begin
                  $display("Unexpected channel %0d value %0d res %0d total %0d last %0d",
                           got.index, got.value, got.resolution, got.total, got.last);
               end
            end else begin
               want = expected_channels.pop_front();
               channels_checked++;
               if (got !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= SHOWN_MISMATCH) begin
                     $display("Mismatch: expected channel %0d value %0d res %0d total %0d last %0d",
                              want.index, want.value, want.resolution, want.total, want.last);
                     $display("          actual   channel %0d value %0d res %0d total %0d last %0d",
                              got.index, got.value, got.resolution, got.total, got.last);
                  end
               end else if (want.last) begin
                  sets_checked++;
                  if (want.resolution) wide_sets++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            decode_packet({req_packet_bytes_high, req_packet_bytes_low});
            packets_taken++;
         end
      end
   end

   initial begin
      int built;
      int made;
      int roll;
      int bad_slot;
      logic wide;

      // An empty packet before any channel is known emits nothing.
      send_packet(1'b0, 16'h0000);
      slot_word[3] = word10(5'd0, 10'h000);
      send_packet(1'b0, 16'h0000);
      // A word whose second byte is 0xFF is still decoded.
      slot_word[1] = word10(5'd1, 10'h3FF);
      slot_word[7] = word10(5'd0, 10'h2FF);
      send_packet(1'b0, 16'hFFFF);
      slot_word[1] = word11(4'd0, 11'h000);
      slot_word[2] = word11(4'd1, 11'h7FF);
      slot_word[5] = word11(4'd5, 11'h4D3);
      send_packet(1'b0, 16'h1234);
      slot_word[2] = word11(4'd2, 11'h2AA);
      slot_word[4] = word11(4'd3, 11'h555);
      slot_word[6] = word11(4'd4, 11'h400);
      send_packet(1'b0, 16'h0000);
      // A bad id keeps what came before it and drops the rest of the packet.
      slot_word[1] = word10(5'd0, 10'h155);
      slot_word[2] = {rcsfd_pkg::ALL_ONES_BYTE, 8'h00};
      slot_word[3] = word10(5'd1, 10'h0AA);
      send_packet(1'b0, 16'h0000);
      for (int c = 1; c <= 5; c++) slot_word[c] = word10(5'(c), 10'(c * 150));
      send_packet(1'b0, 16'hA5A5);
      // A high id next to a 0xFF byte does not make the packet 11-bit.
      slot_word[1] = {8'h30, rcsfd_pkg::ALL_ONES_BYTE};
      slot_word[4] = word10(5'd2, 10'h123);
      send_packet(1'b0, 16'h0000);
      slot_word[1] = word11(4'd0, 11'h7FE);
      slot_word[3] = word11(4'd9, 11'h3C3);
      slot_word[5] = word11(4'd1, 11'h001);
      send_packet(1'b0, 16'h0000);
      for (int c = 2; c <= 8; c++) slot_word[c - 1] = word10(5'(c), 10'(c * 120));
      send_packet(1'b0, 16'h5A5A);
      slot_word[4] = word10(5'd1, 10'h3FF);
      send_packet(1'b0, 16'h0000);
      for (int c = 0; c <= 6; c++) slot_word[c + 1] = word11(4'(c), 11'(c * 340));
      send_packet(1'b0, 16'h0000);
      slot_word[2] = word11(4'd8, 11'h7FF);
      slot_word[6] = word11(4'd7, 11'h000);
      send_packet(1'b0, 16'h0000);
      send_packet(1'b1, 16'hFFFF);

      built = 0;
      while (built < RANDOM_PACKETS) begin
         roll = $urandom_range(0, 99);
         if (roll < 82) begin
            queue_channel_set(made);
            built += made;
         end else begin
            if (roll < 88) begin
               for (int w = 1; w <= 7; w++) slot_word[w] = 16'($urandom);
            end else if (roll < 93) begin
               bad_slot = $urandom_range(1, 7);
               wide = 1'($urandom_range(0, 1));
               for (int w = 1; w <= 7; w++) begin
                  if (w == bad_slot) begin
                     slot_word[w] = wide ? word11(4'($urandom_range(9, 15)), 11'($urandom))
                                         : {rcsfd_pkg::ALL_ONES_BYTE,
                                            8'($urandom_range(0, 254))};
                  end else begin
                     slot_word[w] = wide ? word11(4'($urandom_range(0, 8)), 11'($urandom))
                                         : word10(5'($urandom_range(0, 8)), 10'($urandom));
                  end
               end
            end else if (roll >= 95) begin
               for (int k = $urandom_range(1, 3); k > 0; k--) begin
                  slot_word[$urandom_range(1, 7)] = word10(5'($urandom_range(0, 8)),
                                                           10'($urandom));
               end
            end
            send_packet(1'b0, 16'($urandom));
            built++;
         end
      end

      while (reset) @(negedge clock);
      while (packet_queue.size() != 0 || req_valid) @(negedge clock);
      while (expected_channels.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      mismatch_count += expected_channels.size();

      $display("Decoded %0d packets (%0d cut short by a bad channel id).",
               packets_taken, bad_id_packets);
      $display("Checked %0d channel values in %0d complete sets, %0d of them at 11-bit.",
               channels_checked, sets_checked, wide_sets);
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   initial begin
      #5000000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
